@@ hw/rtl/mvp_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and functions of the mavlink v2 frame parser
// no dependencies

package mvp_pkg;

    localparam logic [7:0]  START_BYTE = 8'hFD;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // crc request: running value, item byte, optional trailing extra byte
    typedef struct packed {
        logic [15:0] crc;
        logic [7:0]  data_byte;
        logic        fold_extra;
        logic [7:0]  extra_byte;
    } crc_req_t;

    // one crc-16/mcrf4xx byte update
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    // per-message crc extra byte, unknown ids give zero
    function automatic logic [7:0] extra_for(input logic [23:0] id);
        logic [7:0] e;
        case (id)
            24'd0:   e = 8'd50;
            24'd1:   e = 8'd124;
            24'd20:  e = 8'd214;
            24'd21:  e = 8'd159;
            24'd22:  e = 8'd220;
            24'd23:  e = 8'd168;
            24'd24:  e = 8'd24;
            24'd30:  e = 8'd39;
            24'd33:  e = 8'd104;
            24'd36:  e = 8'd222;
            24'd65:  e = 8'd118;
            24'd70:  e = 8'd124;
            24'd74:  e = 8'd20;
            24'd76:  e = 8'd152;
            24'd77:  e = 8'd143;
            24'd147: e = 8'd154;
            24'd251: e = 8'd170;
            24'd253: e = 8'd83;
            default: e = 8'd0;
        endcase
        return e;
    endfunction

endpackage

@@ hw/rtl/mavlink_v2_frame_parser.sv @@
`timescale 1ns / 1ps
// mavlink v2 receive framer, top level
// depends on mvp_pkg and mvp_crc_unit
//
// usage
//   s_valid/s_ready/s_rx_byte carry one received link byte per item.
//   m_valid/m_ready carry one result item for every byte taken in.
//   payload bytes stream out with m_payload_valid before the frame is checked;
//   the item of the second checksum byte has m_frame_done set, m_crc_ok and
//   the captured header. drop the buffered payload when m_crc_ok is low.
// pipeline
//   a taken byte is held in the input register, parsed from there, and its
//   result is registered in the result register, which drives m_valid.
//   one item per cycle sustained while m_ready stays high; the input and result
//   registers each advance when the stage after them is empty or being emptied.
// reset
//   aresetn low clears both stages and returns the parser to hunting the
//   start byte with the crc at its initial value.
// stall
//   with m_ready low the result register holds; one more byte may wait in the
//   input register, after which s_ready drops until the result is taken.

module mavlink_v2_frame_parser
    import mvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic        m_frame_done,
    output logic        m_crc_ok,
    output logic [7:0]  m_msg_len,
    output logic [7:0]  m_hdr_incompat,
    output logic [7:0]  m_hdr_compat,
    output logic [7:0]  m_seq_num,
    output logic [7:0]  m_sys_id,
    output logic [7:0]  m_comp_id,
    output logic [23:0] m_msg_id
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEN, ST_INCOMPAT, ST_COMPAT, ST_SEQ, ST_SYSID, ST_COMPID,
        ST_MID0, ST_MID1, ST_MID2, ST_PAYLOAD, ST_CK_LO, ST_CK_HI
    } state_t;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    state_t      state_reg, state_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  incompat_reg, incompat_next;
    logic [7:0]  compat_reg, compat_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  sysid_reg, sysid_next;
    logic [7:0]  compid_reg, compid_next;
    logic [23:0] msgid_reg, msgid_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;
    logic [7:0]  extra_reg, extra_next;

    // result stage
    logic        m_valid_reg;
    logic        pv_reg, pv_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [7:0]  pidx_reg, pidx_next;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;

    logic        adv_out;
    logic        proc;
    crc_req_t    crc_req;
    logic [15:0] crc_upd;
    logic [23:0] mid_full;
    logic [7:0]  mid_extra;
    logic        last_payload;

    assign adv_out = !m_valid_reg || m_ready;
    assign proc    = in_valid_reg && adv_out;
    assign s_ready = !in_valid_reg || adv_out;

    assign mid_full     = {in_byte_reg, msgid_reg[15:0]};
    assign mid_extra    = extra_for(mid_full);
    assign last_payload = ({1'b0, count_reg} + 9'd1) >= {1'b0, len_reg};

    always_comb begin
        crc_req.crc        = crc_reg;
        crc_req.data_byte  = in_byte_reg;
        crc_req.fold_extra = 1'b0;
        crc_req.extra_byte = extra_reg;
        if (state_reg == ST_MID2) begin
            crc_req.fold_extra = (len_reg == 8'd0);
            crc_req.extra_byte = mid_extra;
        end else if (state_reg == ST_PAYLOAD) begin
            crc_req.fold_extra = last_payload;
        end
    end

    mvp_crc_unit u_crc (
        .req     (crc_req),
        .crc_out (crc_upd)
    );

    always_comb begin
        state_next    = state_reg;
        crc_next      = crc_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        incompat_next = incompat_reg;
        compat_next   = compat_reg;
        seq_next      = seq_reg;
        sysid_next    = sysid_reg;
        compid_next   = compid_reg;
        msgid_next    = msgid_reg;
        ck_lo_next    = ck_lo_reg;
        extra_next    = extra_reg;
        pv_next       = 1'b0;
        pbyte_next    = 8'd0;
        pidx_next     = 8'd0;
        done_next     = 1'b0;
        ok_next       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_byte_reg == START_BYTE) begin
                    len_next      = 8'd0;
                    incompat_next = 8'd0;
                    compat_next   = 8'd0;
                    seq_next      = 8'd0;
                    sysid_next    = 8'd0;
                    compid_next   = 8'd0;
                    msgid_next    = 24'd0;
                    ck_lo_next    = 8'd0;
                    count_next    = 8'd0;
                    crc_next      = CRC_INIT;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN: begin
                len_next   = in_byte_reg;
                crc_next   = crc_upd;
                state_next = ST_INCOMPAT;
            end
            ST_INCOMPAT: begin
                incompat_next = in_byte_reg;
                crc_next      = crc_upd;
                state_next    = ST_COMPAT;
            end
            ST_COMPAT: begin
                compat_next = in_byte_reg;
                crc_next    = crc_upd;
                state_next  = ST_SEQ;
            end
            ST_SEQ: begin
                seq_next   = in_byte_reg;
                crc_next   = crc_upd;
                state_next = ST_SYSID;
            end
            ST_SYSID: begin
                sysid_next = in_byte_reg;
                crc_next   = crc_upd;
                state_next = ST_COMPID;
            end
            ST_COMPID: begin
                compid_next = in_byte_reg;
                crc_next    = crc_upd;
                state_next  = ST_MID0;
            end
            ST_MID0: begin
                msgid_next = {16'd0, in_byte_reg};
                crc_next   = crc_upd;
                state_next = ST_MID1;
            end
            ST_MID1: begin
                msgid_next = {8'd0, in_byte_reg, msgid_reg[7:0]};
                crc_next   = crc_upd;
                state_next = ST_MID2;
            end
            ST_MID2: begin
                msgid_next = mid_full;
                extra_next = mid_extra;
                crc_next   = crc_upd;
                count_next = 8'd0;
                state_next = (len_reg == 8'd0) ? ST_CK_LO : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                pv_next    = 1'b1;
                pbyte_next = in_byte_reg;
                pidx_next  = count_reg;
                crc_next   = crc_upd;
                count_next = count_reg + 8'd1;
                if (last_payload) begin
                    state_next = ST_CK_LO;
                end
            end
            ST_CK_LO: begin
                ck_lo_next = in_byte_reg;
                state_next = ST_CK_HI;
            end
            ST_CK_HI: begin
                done_next  = 1'b1;
                ok_next    = ({in_byte_reg, ck_lo_reg} == crc_reg);
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= ST_IDLE;
            crc_reg      <= CRC_INIT;
            len_reg      <= 8'd0;
            count_reg    <= 8'd0;
            incompat_reg <= 8'd0;
            compat_reg   <= 8'd0;
            seq_reg      <= 8'd0;
            sysid_reg    <= 8'd0;
            compid_reg   <= 8'd0;
            msgid_reg    <= 24'd0;
            ck_lo_reg    <= 8'd0;
            extra_reg    <= 8'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv_out) begin
                m_valid_reg <= in_valid_reg;
            end
            if (proc) begin
                state_reg    <= state_next;
                crc_reg      <= crc_next;
                len_reg      <= len_next;
                count_reg    <= count_next;
                incompat_reg <= incompat_next;
                compat_reg   <= compat_next;
                seq_reg      <= seq_next;
                sysid_reg    <= sysid_next;
                compid_reg   <= compid_next;
                msgid_reg    <= msgid_next;
                ck_lo_reg    <= ck_lo_next;
                extra_reg    <= extra_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (proc) begin
            pv_reg    <= pv_next;
            pbyte_reg <= pbyte_next;
            pidx_reg  <= pidx_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    // header fields show only with frame_done; they still hold at that item
    assign m_valid         = m_valid_reg;
    assign m_payload_valid = pv_reg;
    assign m_payload_byte  = pbyte_reg;
    assign m_payload_index = pidx_reg;
    assign m_frame_done    = done_reg;
    assign m_crc_ok        = ok_reg;
    assign m_msg_len       = done_reg ? len_reg : 8'd0;
    assign m_hdr_incompat  = done_reg ? incompat_reg : 8'd0;
    assign m_hdr_compat    = done_reg ? compat_reg : 8'd0;
    assign m_seq_num       = done_reg ? seq_reg : 8'd0;
    assign m_sys_id        = done_reg ? sysid_reg : 8'd0;
    assign m_comp_id       = done_reg ? compid_reg : 8'd0;
    assign m_msg_id        = done_reg ? msgid_reg : 24'd0;

    a_payload_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |-> !m_frame_done)
        else $error("payload item flagged as frame end");

    a_ok_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_done |-> !m_crc_ok)
        else $error("crc verdict outside frame end");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PAYLOAD |-> count_reg < len_reg)
        else $error("payload count reached frame length");

    a_end_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && state_reg == ST_CK_HI |=> state_reg == ST_IDLE && m_frame_done)
        else $error("frame end did not return to idle");

    a_stall_no_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv_out |=> $stable(state_reg) && $stable(crc_reg))
        else $error("parser advanced while result stalled");

endmodule

@@ hw/rtl/mvp_crc_unit.sv @@
`timescale 1ns / 1ps
// crc-16/mcrf4xx update of one byte, optionally followed by the extra byte
// depends on mvp_pkg

module mvp_crc_unit
    import mvp_pkg::*;
(
    input  crc_req_t    req,
    output logic [15:0] crc_out
);

    logic [15:0] crc_first;

    assign crc_first = crc_fold(req.crc, req.data_byte);
    assign crc_out   = req.fold_extra ? crc_fold(crc_first, req.extra_byte) : crc_first;

endmodule

@@ tb/sv/mavlink_v2_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for mavlink_v2_frame_parser: directed byte table, then random frames
// depends on mvp_pkg (start byte, crc init) and the mavlink_v2_frame_parser rtl

module mavlink_v2_frame_parser_tb
    import mvp_pkg::*;
();

    localparam int          RANDOM_ITEMS = 1450;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_FRAME   = 8;
    localparam int          DRAIN_LIMIT  = 100000;
    localparam int          MSG_TABLE_N  = 18;
    localparam logic [15:0] CRC_POLY_REF = 16'h8408;

    typedef enum logic [3:0] {
        PH_HUNT, PH_LEN, PH_INCOMPAT, PH_COMPAT, PH_SEQ, PH_SYSID, PH_COMPID,
        PH_MID0, PH_MID1, PH_MID2, PH_PAYLOAD, PH_CK_LO, PH_CK_HI
    } rx_phase_t;

    typedef enum logic [1:0] {ITEM_RAW, ITEM_CK_LO, ITEM_CK_HI} item_kind_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_done;
        logic        crc_ok;
        logic [7:0]  msg_len;
        logic [7:0]  hdr_incompat;
        logic [7:0]  hdr_compat;
        logic [7:0]  seq_num;
        logic [7:0]  sys_id;
        logic [7:0]  comp_id;
        logic [23:0] msg_id;
    } parser_result_t;

    typedef struct packed {
        item_kind_t     kind;
        logic [7:0]     value;
        logic           typed;
        parser_result_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_payload_index;
    logic        m_frame_done;
    logic        m_crc_ok;
    logic [7:0]  m_msg_len;
    logic [7:0]  m_hdr_incompat;
    logic [7:0]  m_hdr_compat;
    logic [7:0]  m_seq_num;
    logic [7:0]  m_sys_id;
    logic [7:0]  m_comp_id;
    logic [23:0] m_msg_id;

    // predictor state
    rx_phase_t   rx_phase = PH_HUNT;
    logic [15:0] rx_crc = CRC_INIT;
    logic [7:0]  rx_len = '0;
    logic [7:0]  rx_count = '0;
    logic [7:0]  rx_incompat = '0;
    logic [7:0]  rx_compat = '0;
    logic [7:0]  rx_seq = '0;
    logic [7:0]  rx_sys = '0;
    logic [7:0]  rx_comp = '0;
    logic [23:0] rx_mid = '0;
    logic [7:0]  rx_ck_lo = '0;

    parser_result_t results_due[$];
    parser_result_t typed_result = '0;
    bit             use_typed = 1'b0;
    bit             steady_sender = 1'b0;
    bit             hold_off_req = 1'b0;
    int             fails = 0;
    int             items_sent = 0;
    int             bytes_taken = 0;
    int             frames_good = 0;
    int             frames_bad = 0;
    int             payload_streamed = 0;
    int             longest_payload = 0;

    mavlink_v2_frame_parser u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_done    (m_frame_done),
        .m_crc_ok        (m_crc_ok),
        .m_msg_len       (m_msg_len),
        .m_hdr_incompat  (m_hdr_incompat),
        .m_hdr_compat    (m_hdr_compat),
        .m_seq_num       (m_seq_num),
        .m_sys_id        (m_sys_id),
        .m_comp_id       (m_comp_id),
        .m_msg_id        (m_msg_id)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("mavlink_v2_frame_parser_tb NOT OK");
        $finish;
    end

    // known message ids and their crc extra bytes, packed as {id, extra}
    function automatic logic [31:0] msg_entry(input int idx);
        logic [31:0] ent;
        case (idx)
            0:       ent = {24'd0,   8'd50};
            1:       ent = {24'd1,   8'd124};
            2:       ent = {24'd20,  8'd214};
            3:       ent = {24'd21,  8'd159};
            4:       ent = {24'd22,  8'd220};
            5:       ent = {24'd23,  8'd168};
            6:       ent = {24'd24,  8'd24};
            7:       ent = {24'd30,  8'd39};
            8:       ent = {24'd33,  8'd104};
            9:       ent = {24'd36,  8'd222};
            10:      ent = {24'd65,  8'd118};
            11:      ent = {24'd70,  8'd124};
            12:      ent = {24'd74,  8'd20};
            13:      ent = {24'd76,  8'd152};
            14:      ent = {24'd77,  8'd143};
            15:      ent = {24'd147, 8'd154};
            16:      ent = {24'd251, 8'd170};
            default: ent = {24'd253, 8'd83};
        endcase
        return ent;
    endfunction

    function automatic logic [7:0] extra_of(input logic [23:0] id);
        logic [31:0] ent;
        logic [7:0]  e;
        e = '0;
        for (int i = 0; i < MSG_TABLE_N; i++) begin
            ent = msg_entry(i);
            if (ent[31:8] == id) e = ent[7:0];
        end
        return e;
    endfunction

    // bitwise reflected crc-16, one byte
    function automatic logic [15:0] crc_mcrf4xx(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) v = v[0] ? ((v >> 1) ^ CRC_POLY_REF) : (v >> 1);
        return v;
    endfunction

    // advances the predictor by one taken byte and returns the result it should give
    function automatic parser_result_t parse_rx_byte(input logic [7:0] b);
        parser_result_t r;
        r = '0;
        case (rx_phase)
            PH_HUNT: begin
                if (b == START_BYTE) begin
                    rx_len      = '0;
                    rx_incompat = '0;
                    rx_compat   = '0;
                    rx_seq      = '0;
                    rx_sys      = '0;
                    rx_comp     = '0;
                    rx_mid      = '0;
                    rx_ck_lo    = '0;
                    rx_count    = '0;
                    rx_crc      = CRC_INIT;
                    rx_phase    = PH_LEN;
                end
            end
            PH_LEN: begin
                rx_len = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_INCOMPAT;
            end
            PH_INCOMPAT: begin
                rx_incompat = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_COMPAT;
            end
            PH_COMPAT: begin
                rx_compat = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_SEQ;
            end
            PH_SEQ: begin
                rx_seq = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_SYSID;
            end
            PH_SYSID: begin
                rx_sys = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_COMPID;
            end
            PH_COMPID: begin
                rx_comp = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_MID0;
            end
            PH_MID0: begin
                rx_mid = {16'h0000, b};
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_MID1;
            end
            PH_MID1: begin
                rx_mid[15:8] = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_phase = PH_MID2;
            end
            PH_MID2: begin
                rx_mid[23:16] = b;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                rx_count = '0;
                if (rx_len == 8'd0) begin
                    rx_crc = crc_mcrf4xx(rx_crc, extra_of(rx_mid));
                    rx_phase = PH_CK_LO;
                end else begin
                    rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = rx_count;
                rx_crc = crc_mcrf4xx(rx_crc, b);
                if ({1'b0, rx_count} + 9'd1 >= {1'b0, rx_len}) begin
                    rx_crc = crc_mcrf4xx(rx_crc, extra_of(rx_mid));
                    rx_phase = PH_CK_LO;
                end
                rx_count = rx_count + 8'd1;
            end
            PH_CK_LO: begin
                rx_ck_lo = b;
                rx_phase = PH_CK_HI;
            end
            PH_CK_HI: begin
                r.frame_done   = 1'b1;
                r.crc_ok       = ({b, rx_ck_lo} == rx_crc);
                r.msg_len      = rx_len;
                r.hdr_incompat = rx_incompat;
                r.hdr_compat   = rx_compat;
                r.seq_num      = rx_seq;
                r.sys_id       = rx_sys;
                r.comp_id      = rx_comp;
                r.msg_id       = rx_mid;
                rx_phase = PH_HUNT;
            end
            default: begin
                rx_phase = PH_HUNT;
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t mk_row(input item_kind_t kind, input logic [7:0] value,
                                         input logic typed, input parser_result_t want);
        stim_row_t row;
        row.kind  = kind;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic parser_result_t done_result(input logic ok, input logic [7:0] len,
            input logic [7:0] inc, input logic [7:0] cmp, input logic [7:0] seq,
            input logic [7:0] sys, input logic [7:0] cid, input logic [23:0] mid);
        parser_result_t r;
        r = '0;
        r.frame_done   = 1'b1;
        r.crc_ok       = ok;
        r.msg_len      = len;
        r.hdr_incompat = inc;
        r.hdr_compat   = cmp;
        r.seq_num      = seq;
        r.sys_id       = sys;
        r.comp_id      = cid;
        r.msg_id       = mid;
        return r;
    endfunction

    task automatic check_result(input parser_result_t want);
        if (m_payload_valid !== want.payload_valid) begin
            $error("payload_valid: expected %0h, got %0h", want.payload_valid, m_payload_valid);
            fails++;
        end
        if (m_payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, m_payload_byte);
            fails++;
        end
        if (m_payload_index !== want.payload_index) begin
            $error("payload_index: expected %0d, got %0d", want.payload_index, m_payload_index);
            fails++;
        end
        if (m_frame_done !== want.frame_done) begin
            $error("frame_done: expected %0h, got %0h", want.frame_done, m_frame_done);
            fails++;
        end
        if (m_crc_ok !== want.crc_ok) begin
            $error("crc_ok: expected %0h, got %0h", want.crc_ok, m_crc_ok);
            fails++;
        end
        if (m_msg_len !== want.msg_len) begin
            $error("msg_len: expected %0d, got %0d", want.msg_len, m_msg_len);
            fails++;
        end
        if (m_hdr_incompat !== want.hdr_incompat) begin
            $error("hdr_incompat: expected %0h, got %0h", want.hdr_incompat, m_hdr_incompat);
            fails++;
        end
        if (m_hdr_compat !== want.hdr_compat) begin
            $error("hdr_compat: expected %0h, got %0h", want.hdr_compat, m_hdr_compat);
            fails++;
        end
        if (m_seq_num !== want.seq_num) begin
            $error("seq_num: expected %0h, got %0h", want.seq_num, m_seq_num);
            fails++;
        end
        if (m_sys_id !== want.sys_id) begin
            $error("sys_id: expected %0h, got %0h", want.sys_id, m_sys_id);
            fails++;
        end
        if (m_comp_id !== want.comp_id) begin
            $error("comp_id: expected %0h, got %0h", want.comp_id, m_comp_id);
            fails++;
        end
        if (m_msg_id !== want.msg_id) begin
            $error("msg_id: expected %0h, got %0h", want.msg_id, m_msg_id);
            fails++;
        end
    endtask

    // checksum items take the predicted crc byte xor value, so a zero value gives a good checksum
    task automatic send_item(input item_kind_t kind, input logic [7:0] value, input bit typed,
                             input parser_result_t want, input bit counted);
        int         gap;
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 65) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        case (kind)
            ITEM_CK_LO: b = rx_crc[7:0] ^ value;
            ITEM_CK_HI: b = rx_crc[15:8] ^ value;
            default:    b = value;
        endcase
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        use_typed    = typed;
        typed_result = want;
        if (counted) items_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_frame(input int frame_no);
        int          len;
        int          r;
        int          n_noise;
        logic [31:0] ent;
        logic [23:0] mid;
        logic [7:0]  mask_lo;
        logic [7:0]  mask_hi;
        logic [7:0]  nb;
        bit          garbage;
        r = $urandom_range(0, 99);
        n_noise = (r < 25) ? $urandom_range(1, 4) : 0;
        for (int i = 0; i < n_noise; i++) begin
            nb = 8'($urandom);
            if (nb == START_BYTE) nb = ~START_BYTE;
            send_item(ITEM_RAW, nb, 1'b0, '0, 1'b0);
        end

        r = $urandom_range(0, 99);
        if (frame_no == 3) len = 255;
        else if (frame_no == HOLD_FRAME) len = 120;
        else if (r < 2) len = 255;
        else if (r < 6) len = $urandom_range(65, 254);
        else if (r < 20) len = $urandom_range(17, 64);
        else len = $urandom_range(0, 16);

        r = $urandom_range(0, 99);
        ent = msg_entry($urandom_range(0, MSG_TABLE_N - 1));
        if (r < 60) mid = ent[31:8];
        else if (r < 80) mid = 24'($urandom_range(0, 255));
        else mid = 24'($urandom);

        mask_lo = '0;
        mask_hi = '0;
        garbage = 1'b0;
        r = $urandom_range(0, 99);
        if (r >= 96) garbage = 1'b1;
        else if (r >= 88) mask_hi = 8'($urandom_range(1, 255));
        else if (r >= 78) mask_lo = 8'h01 << $urandom_range(0, 7);

        send_item(ITEM_RAW, START_BYTE, 1'b0, '0, 1'b1);
        send_item(ITEM_RAW, len[7:0], 1'b0, '0, 1'b1);
        repeat (5) send_item(ITEM_RAW, 8'($urandom), 1'b0, '0, 1'b1);
        send_item(ITEM_RAW, mid[7:0], 1'b0, '0, 1'b1);
        send_item(ITEM_RAW, mid[15:8], 1'b0, '0, 1'b1);
        send_item(ITEM_RAW, mid[23:16], 1'b0, '0, 1'b1);
        repeat (len) send_item(ITEM_RAW, 8'($urandom), 1'b0, '0, 1'b1);
        if (garbage) begin
            repeat (2) send_item(ITEM_RAW, 8'($urandom), 1'b0, '0, 1'b1);
        end else begin
            send_item(ITEM_CK_LO, mask_lo, 1'b0, '0, 1'b1);
            send_item(ITEM_CK_HI, mask_hi, 1'b0, '0, 1'b1);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        parser_result_t due;
        parser_result_t predicted;
        if (!aresetn) begin
            rx_phase = PH_HUNT;
            rx_crc   = CRC_INIT;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result item with nothing expected");
                    fails++;
                end else begin
                    due = results_due.pop_front();
                    check_result(due);
                end
            end
            if (s_valid && s_ready) begin
                predicted = parse_rx_byte(s_rx_byte);
                if (use_typed) predicted = typed_result;
                results_due.push_back(predicted);
                bytes_taken++;
                if (predicted.payload_valid) payload_streamed++;
                if (predicted.frame_done) begin
                    if (predicted.crc_ok) frames_good++;
                    else frames_bad++;
                    if (int'(predicted.msg_len) > longest_payload) begin
                        longest_payload = int'(predicted.msg_len);
                    end
                end
            end
        end
    end

    initial begin : result_sink
        int run_len;
        int stall_len;
        int r;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge aclk) m_ready <= 1'b0;
                for (int held = 1; held < HOLD_CYCLES; held++) @(negedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                run_len = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 20);
                @(negedge aclk) m_ready <= 1'b1;
                for (int i = 1; i < run_len && !hold_off_req; i++) @(negedge aclk);
                r = $urandom_range(0, 99);
                if (r < 70) stall_len = $urandom_range(1, 2);
                else if (r < 95) stall_len = $urandom_range(3, 8);
                else stall_len = $urandom_range(20, 60);
                if (!hold_off_req) begin
                    @(negedge aclk) m_ready <= 1'b0;
                    repeat (stall_len - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t      rows[$];
        parser_result_t pay;
        int             frame_no;
        int             random_start;
        int             drain;

        pay = '0;
        pay.payload_valid = 1'b1;
        pay.payload_byte  = START_BYTE;

        // noise after reset, then a zero-length heartbeat with a bad checksum
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, START_BYTE, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_CK_LO, 8'h01, 1'b0, '0));
        rows.push_back(mk_row(ITEM_CK_HI, 8'h00, 1'b1,
            done_result(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 24'h000000)));
        // one payload byte, unknown id, start byte inside the frame, good checksum
        rows.push_back(mk_row(ITEM_RAW, START_BYTE, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h01, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'h00, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, START_BYTE, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, 8'hFF, 1'b1, '0));
        rows.push_back(mk_row(ITEM_RAW, START_BYTE, 1'b1, pay));
        rows.push_back(mk_row(ITEM_CK_LO, 8'h00, 1'b0, '0));
        rows.push_back(mk_row(ITEM_CK_HI, 8'h00, 1'b1,
            done_result(1'b1, 8'h01, 8'h00, 8'hFF, 8'h00, START_BYTE, 8'hFF, 24'hFFFFFF)));

        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (rows[i]) send_item(rows[i].kind, rows[i].value, rows[i].typed, rows[i].want, 1'b1);

        frame_no = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            steady_sender = ($urandom_range(0, 4) == 0);
            if (frame_no == HOLD_FRAME) begin
                steady_sender = 1'b0;
                hold_off_req = 1'b1;
            end
            if (frame_no == 20 || frame_no == 40) begin
                @(negedge aclk) s_valid <= 1'b0;
                while (results_due.size() != 0) @(posedge aclk);
            end
            send_random_frame(frame_no);
            frame_no++;
        end

        @(negedge aclk) s_valid <= 1'b0;
        drain = 0;
        while (results_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (8) @(posedge aclk);
        if (results_due.size() != 0) begin
            $error("%0d expected result items never arrived", results_due.size());
            fails++;
        end

        $display("bytes taken %0d over %0d random frames plus the directed table", bytes_taken,
                 frame_no);
        $display("frames ended %0d with good crc, %0d with bad; %0d payload bytes, longest %0d",
                 frames_good, frames_bad, payload_streamed, longest_payload);
        if (fails == 0) begin
            $display("mavlink_v2_frame_parser_tb OK");
        end else begin
            $display("mavlink_v2_frame_parser_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ mavlink_v2_frame_parser.f @@
hw/rtl/mvp_pkg.sv
hw/rtl/mvp_crc_unit.sv
hw/rtl/mavlink_v2_frame_parser.sv
tb/sv/mavlink_v2_frame_parser_tb.sv
